// ===== rtl/isp_pkg.sv =====
// Shared widths, field layout, command/status types and state codes of the path counter.
package isp_pkg;

  // Default and limit of the order clamp
  localparam int unsigned MAX_ORDER_DEF = 63;

  // Input field widths
  localparam int unsigned ORDER_W = 6;
  localparam int unsigned ROOM_W  = 16;
  localparam int unsigned SPEED_W = 13;
  localparam int unsigned TIME_W  = 16;

  // Input field offsets inside tdata, lowest field first
  localparam int unsigned ORDER_LSB = 0;
  localparam int unsigned RX_LSB    = ORDER_LSB + ORDER_W;
  localparam int unsigned RY_LSB    = RX_LSB + ROOM_W;
  localparam int unsigned RZ_LSB    = RY_LSB + ROOM_W;
  localparam int unsigned SPEED_LSB = RZ_LSB + ROOM_W;
  localparam int unsigned TIME_LSB  = SPEED_LSB + SPEED_W;
  localparam int unsigned IN_BITS   = TIME_LSB + TIME_W;
  localparam int unsigned IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  // Result field
  localparam int unsigned COUNT_W     = 19;
  localparam int unsigned OUT_TDATA_W = ((COUNT_W + 7) / 8) * 8;

  // Arithmetic widths
  localparam int unsigned SQ_W        = 2 * ROOM_W;
  localparam int unsigned PROD_W      = SPEED_W + TIME_W;
  localparam int unsigned RANGE_W     = 2 * PROD_W;
  localparam int unsigned RANGE_SHIFT = 12;

  // Axis of a term pushed into the distance pipeline
  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANGE,
    ST_X,
    ST_Y,
    ST_Z,
    ST_DRAIN
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic  load;
    logic  range_calc;
    logic  i_first;
    logic  i_next;
    logic  j_first;
    logic  j_next;
    logic  k_first;
    logic  k_next;
    logic  issue;
    axis_e axis;
    logic  publish;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic i_last;
    logic j_last;
    logic k_last;
    logic busy;
  } status_t;

endpackage

// ===== rtl/isp_ctrl.sv =====
// Walk sequencer and stream handshake control of the path counter.
module isp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  isp_pkg::status_t status_i,
  output isp_pkg::cmd_t   cmd_o
);
  import isp_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // State and output-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.axis = AXIS_X;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RANGE;
        end
      end
      ST_RANGE: begin
        cmd_o.range_calc = 1'b1;
        cmd_o.i_first    = 1'b1;
        state_d          = ST_X;
      end
      ST_X: begin
        cmd_o.issue   = 1'b1;
        cmd_o.axis    = AXIS_X;
        cmd_o.j_first = 1'b1;
        state_d       = ST_Y;
      end
      ST_Y: begin
        cmd_o.issue   = 1'b1;
        cmd_o.axis    = AXIS_Y;
        cmd_o.k_first = 1'b1;
        state_d       = ST_Z;
      end
      ST_Z: begin
        cmd_o.issue = 1'b1;
        cmd_o.axis  = AXIS_Z;
        priority if (!status_i.k_last) begin
          cmd_o.k_next = 1'b1;
        end else if (!status_i.j_last) begin
          cmd_o.j_next = 1'b1;
          state_d      = ST_Y;
        end else if (!status_i.i_last) begin
          cmd_o.i_next = 1'b1;
          state_d      = ST_X;
        end else begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the pipeline to empty and the output register to be free
        if (!status_i.busy && (!out_valid_q || out_ready_i)) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the result until the transfer completes
  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.publish;
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/isp_datapath.sv =====
// Walk counters, distance pipeline, range compare and count register of the path counter.
module isp_datapath #(
  parameter int unsigned MAX_ORDER = isp_pkg::MAX_ORDER_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  isp_pkg::cmd_t                   cmd_i,
  input  logic [isp_pkg::IN_TDATA_W-1:0]  in_data_i,
  output isp_pkg::status_t                status_o,
  output logic [isp_pkg::COUNT_W-1:0]     count_o
);
  import isp_pkg::*;

  localparam int unsigned OW   = $clog2(MAX_ORDER + 1);
  localparam int unsigned CW   = OW + 1;
  localparam int unsigned AW   = $clog2(MAX_ORDER + 2);
  localparam int unsigned FW   = 2 * AW;
  localparam int unsigned TW   = SQ_W + FW;
  localparam int unsigned DW   = TW + 2;
  localparam int unsigned LW   = DW + RANGE_SHIFT;
  localparam int unsigned CMPW = (LW > RANGE_W) ? LW : RANGE_W;
  localparam int unsigned CLW  = (OW > ORDER_W) ? OW : ORDER_W;

  function automatic logic [CW-1:0] abs_c(input logic [CW-1:0] v);
    return v[CW-1] ? (CW'(0) - v) : v;
  endfunction

  // Input fields
  logic [ORDER_W-1:0] ord_in;
  logic [ROOM_W-1:0]  rx_in, ry_in, rz_in;
  logic [SPEED_W-1:0] spd_in;
  logic [TIME_W-1:0]  tim_in;

  assign ord_in = in_data_i[ORDER_LSB +: ORDER_W];
  assign rx_in  = in_data_i[RX_LSB +: ROOM_W];
  assign ry_in  = in_data_i[RY_LSB +: ROOM_W];
  assign rz_in  = in_data_i[RZ_LSB +: ROOM_W];
  assign spd_in = in_data_i[SPEED_LSB +: SPEED_W];
  assign tim_in = in_data_i[TIME_LSB +: TIME_W];

  // Clamp the order
  logic [CLW-1:0] ord_ext, max_ext;
  logic [OW-1:0]  n_d;

  assign ord_ext = CLW'(ord_in);
  assign max_ext = CLW'(MAX_ORDER);
  assign n_d     = (ord_ext > max_ext) ? max_ext[OW-1:0] : ord_ext[OW-1:0];

  // Item registers
  logic [OW-1:0]      n_q;
  logic [SQ_W-1:0]    sq_x_q, sq_y_q, sq_z_q;
  logic [PROD_W-1:0]  prod_q;
  logic [RANGE_W-1:0] range_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q    <= n_d;
      sq_x_q <= SQ_W'(rx_in) * SQ_W'(rx_in);
      sq_y_q <= SQ_W'(ry_in) * SQ_W'(ry_in);
      sq_z_q <= SQ_W'(rz_in) * SQ_W'(rz_in);
      prod_q <= PROD_W'(spd_in) * PROD_W'(tim_in);
    end
    if (cmd_i.range_calc) begin
      range_q <= RANGE_W'(prod_q) * RANGE_W'(prod_q);
    end
  end

  // Walk counters
  logic signed [CW-1:0] i_q, j_q, k_q;
  logic [CW-1:0]        rem_i_q, rem_j_q;
  logic [CW-1:0]        n_ext, rem_i_d, rem_j_d;

  assign n_ext   = {1'b0, n_q};
  assign rem_i_d = n_ext - abs_c(i_q);
  assign rem_j_d = rem_i_q - abs_c(j_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      rem_i_q <= '0;
      rem_j_q <= '0;
    end else begin
      if (cmd_i.i_first) begin
        i_q <= CW'(0) - n_ext;
      end else if (cmd_i.i_next) begin
        i_q <= i_q + CW'(1);
      end
      if (cmd_i.j_first) begin
        rem_i_q <= rem_i_d;
        j_q     <= CW'(0) - rem_i_d;
      end else if (cmd_i.j_next) begin
        j_q <= j_q + CW'(1);
      end
      if (cmd_i.k_first) begin
        rem_j_q <= rem_j_d;
        k_q     <= CW'(0) - rem_j_d;
      end else if (cmd_i.k_next) begin
        k_q <= k_q + CW'(1);
      end
    end
  end

  assign status_o.i_last = (i_q == n_ext);
  assign status_o.j_last = (j_q == rem_i_q);
  assign status_o.k_last = (k_q == rem_j_q);

  // Stage 0: pick the axis, form the reflection factor and square it
  logic [CW-1:0]   sel_v;
  logic [SQ_W-1:0] sel_sq;
  logic [CW:0]     fac, fac_abs;
  logic [AW-1:0]   absf;
  logic [FW-1:0]   fsq;

  always_comb begin
    unique case (cmd_i.axis)
      AXIS_X: begin
        sel_v  = i_q;
        sel_sq = sq_x_q;
      end
      AXIS_Y: begin
        sel_v  = j_q;
        sel_sq = sq_y_q;
      end
      default: begin
        sel_v  = k_q;
        sel_sq = sq_z_q;
      end
    endcase
  end

  assign fac     = sel_v[0] ? {sel_v[CW-1], sel_v} : ({sel_v[CW-1], sel_v} - (CW+1)'(1));
  assign fac_abs = fac[CW] ? ((CW+1)'(0) - fac) : fac;
  assign absf    = fac_abs[AW-1:0];
  assign fsq     = FW'(absf) * FW'(absf);

  // Pipeline registers
  logic            p1_valid_q, p2_valid_q;
  axis_e           p1_axis_q, p2_axis_q;
  logic [FW-1:0]   p1_fsq_q;
  logic [SQ_W-1:0] p1_sq_q;
  logic [TW-1:0]   p2_term_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
    end else begin
      p1_valid_q <= cmd_i.issue;
      p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_axis_q <= cmd_i.axis;
    p1_fsq_q  <= fsq;
    p1_sq_q   <= sel_sq;
    // Stage 1: scale the squared factor by the squared room dimension
    p2_axis_q <= p1_axis_q;
    p2_term_q <= TW'(p1_sq_q) * TW'(p1_fsq_q);
  end

  assign status_o.busy = p1_valid_q || p2_valid_q;

  // Stage 2: accumulate the distance and compare against the range
  logic [TW-1:0]   dx_q;
  logic [TW:0]     dxy_q;
  logic [DW-1:0]   d_sum;
  logic [CMPW-1:0] lhs, rhs;
  logic            hit;

  assign d_sum = DW'(dxy_q) + DW'(p2_term_q);
  assign lhs   = CMPW'({d_sum, {RANGE_SHIFT{1'b0}}});
  assign rhs   = CMPW'(range_q);
  assign hit   = (lhs < rhs);

  always_ff @(posedge clk_i) begin
    if (p2_valid_q && (p2_axis_q == AXIS_X)) begin
      dx_q <= p2_term_q;
    end
    if (p2_valid_q && (p2_axis_q == AXIS_Y)) begin
      dxy_q <= (TW+1)'(dx_q) + (TW+1)'(p2_term_q);
    end
  end

  // Count the hits and hold the finished count
  logic [COUNT_W-1:0] total_q, result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= '0;
      result_q <= '0;
    end else begin
      if (cmd_i.load) begin
        total_q <= '0;
      end else if (p2_valid_q && (p2_axis_q == AXIS_Z) && hit) begin
        total_q <= total_q + COUNT_W'(1);
      end
      if (cmd_i.publish) begin
        result_q <= total_q;
      end
    end
  end

  assign count_o = result_q;

endmodule

// ===== rtl/image_source_path_counter.sv =====
// Top level of the shoebox image source path counter.
//
// Input stream (s_axis): one transfer carries the order, the room size, the
// speed of sound and the decay time. Output stream (m_axis): one transfer per
// input carries the number of image sources strictly inside the travel range.
// An input is taken only while the block is idle; the walk covers one lattice
// point per cycle within a row through a three-stage distance pipeline (factor
// square, scale by squared room size, add and compare). After the load and
// the range step, the walk spends a step on each plane, each row and each
// point, and then drains the pipeline.
// The finished count sits in an output register: a new input is accepted
// while it waits, and if the receiver stalls past the next walk, the block
// holds in its drain state until the earlier transfer completes.
// Reset clears the controller, the walk counters, the pipeline valid bits and
// the count; no output is pending after reset.
module image_source_path_counter #(
  parameter int unsigned MAX_ORDER = isp_pkg::MAX_ORDER_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // max_order[5:0], room_x[21:6], room_y[37:22], room_z[53:38],
  // sound_speed[66:54], decay_time[82:67], zero[87:83]
  input  logic [isp_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // path_count[18:0], zero[23:19]
  output logic [isp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i
);
  import isp_pkg::*;

  cmd_t               cmd;
  status_t            status;
  logic [COUNT_W-1:0] count;

  isp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  isp_datapath #(
    .MAX_ORDER (MAX_ORDER)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_data_i (s_axis_tdata_i),
    .status_o  (status),
    .count_o   (count)
  );

  // Pad the count up to whole bytes
  assign m_axis_tdata_o = OUT_TDATA_W'(count);

endmodule
